FILE: sv/video_ram_palette_controller_defines.svh
// ============================================================================
// Assertion macros for the video RAM palette controller
// Shared shorthand for the concurrent checks on the block's ports.
// ============================================================================
`ifndef VIDEO_RAM_PALETTE_CONTROLLER_DEFINES_SVH
`define VIDEO_RAM_PALETTE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define VRPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define VRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vrpc_pkg.sv
// ============================================================================
// Video RAM palette controller package
// Operation codes, controller/datapath interface types and the level table.
// ============================================================================
package vrpc_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [3:0] OP_WIN_RD = 4'd0;
    localparam logic [3:0] OP_WIN_WR = 4'd1;
    localparam logic [3:0] OP_LAT_RD = 4'd2;
    localparam logic [3:0] OP_LAT_WR = 4'd3;
    localparam logic [3:0] OP_LAT_HI = 4'd4;
    localparam logic [3:0] OP_LAT_LO = 4'd5;
    localparam logic [3:0] OP_PAL_WR = 4'd6;
    localparam logic [3:0] OP_PAGE   = 4'd7;
    localparam logic [3:0] OP_FETCH  = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture the accepted request
        logic frame_acc;  // frame store access and register updates
        logic pal_rd;     // palette store read
        logic load_out;   // fill the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pixel;   // request produces a pixel report
        logic out_free;   // output register can take a new result
    } t_stat;

    // Intensity level table, indexed by {color, intensity}.
    function automatic logic [7:0] level(input logic [3:0] idx);
        logic [7:0] lv;
        case (idx)
            4'd0:    lv = 8'h00;
            4'd1:    lv = 8'h12;
            4'd2:    lv = 8'h24;
            4'd3:    lv = 8'h49;
            4'd4:    lv = 8'h12;
            4'd5:    lv = 8'h24;
            4'd6:    lv = 8'h49;
            4'd7:    lv = 8'h92;
            4'd8:    lv = 8'h5b;
            4'd9:    lv = 8'h6d;
            4'd10:   lv = 8'h92;
            4'd11:   lv = 8'hdb;
            4'd12:   lv = 8'h7f;
            4'd13:   lv = 8'h91;
            4'd14:   lv = 8'hb6;
            default: lv = 8'hff;
        endcase
        return lv;
    endfunction

endpackage

FILE: sv/vrpc_ctrl.sv
// ============================================================================
// Video RAM palette controller sequencer
// Steps one request through capture, frame access, pixel palette read, output.
// ============================================================================
module vrpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  vrpc_pkg::t_stat i_stat,
    output vrpc_pkg::t_cmd  o_cmd
);
    import vrpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRAME,
        S_PAL,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_ready;

    // State register and the registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid && r_ready) begin
                        r_state <= S_FRAME;
                        r_ready <= 1'b0;
                    end
                end
                S_FRAME: begin
                    r_state <= i_stat.is_pixel ? S_PAL : S_OUT;
                end
                S_PAL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    // Commands decoded from the current state.
    always_comb begin
        o_cmd.load_in   = i_s_axis_tvalid && r_ready;
        o_cmd.frame_acc = (r_state == S_FRAME);
        o_cmd.pal_rd    = (r_state == S_PAL);
        o_cmd.load_out  = (r_state == S_OUT) && i_stat.out_free;
    end

    assign o_s_axis_tready = r_ready;

endmodule

FILE: sv/vrpc_datapath.sv
// ============================================================================
// Video RAM palette controller datapath
// Frame and palette stores, address latch, page and orientation registers.
// ============================================================================
module vrpc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vrpc_pkg::t_cmd  i_cmd,
    output vrpc_pkg::t_stat o_stat,
    input  logic [3:0]      i_op,
    input  logic [15:0]     i_address,
    input  logic [7:0]      i_data,
    input  logic            i_cfg_wr_en,
    input  logic [2:0]      i_cfg_wr_data,
    input  logic            i_m_axis_tready,
    output logic            o_m_axis_tvalid,
    output logic [47:0]     o_m_axis_tdata,
    output logic            o_m_axis_tuser
);
    import vrpc_pkg::*;

    logic [7:0]  frame_mem [65536];
    logic [7:0]  pal_mem   [1024];

    logic [3:0]  r_op;
    logic [15:0] r_addr;
    logic [15:0] r_frame_addr;
    logic [7:0]  r_data;
    logic [7:0]  r_frame_q;
    logic [7:0]  r_pal_q;
    logic [7:0]  r_latch_hi;
    logic [7:0]  r_latch_lo;
    logic [1:0]  r_page;
    logic [2:0]  r_orient;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_pix;

    logic        is_read;
    logic        is_write;
    logic        is_pixel;
    logic [15:0] n_frame_addr;
    logic [7:0]  pix;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [1:0]  inten;

    // Operation classes.
    always_comb begin
        is_read  = 1'b0;
        is_write = 1'b0;
        is_pixel = 1'b0;
        case (r_op) inside
            OP_WIN_RD, OP_LAT_RD: begin
                is_read = 1'b1;
            end
            OP_WIN_WR, OP_LAT_WR: begin
                is_write = 1'b1;
                is_pixel = 1'b1;
            end
            OP_FETCH: begin
                is_read  = 1'b1;
                is_pixel = 1'b1;
            end
            default: begin
                is_read = 1'b0;
            end
        endcase
    end

    // Frame address from the incoming request and the current latch.
    always_comb begin
        case (i_op) inside
            OP_WIN_RD, OP_WIN_WR: n_frame_addr = {r_latch_hi[7], i_address[14:0]};
            OP_LAT_RD, OP_LAT_WR: n_frame_addr = {r_latch_hi, r_latch_lo};
            default:              n_frame_addr = i_address;
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op         <= i_op;
            r_addr       <= i_address;
            r_data       <= i_data;
            r_frame_addr <= n_frame_addr;
        end
    end

    // Frame store: one access per request, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_acc) begin
            if (is_write) begin
                frame_mem[r_frame_addr] <= r_data;
            end
            r_frame_q <= frame_mem[r_frame_addr];
        end
    end

    // Pixel byte: the written byte, or the fetched one.
    assign pix = (r_op == OP_FETCH) ? r_frame_q : r_data;

    // Palette store: writes in the frame step, reads in the palette step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_acc && (r_op == OP_PAL_WR)) begin
            pal_mem[r_addr[9:0]] <= r_data;
        end
        if (i_cmd.pal_rd) begin
            r_pal_q <= pal_mem[{r_page, pix}];
        end
    end

    // Latch, page and orientation registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_hi <= '0;
            r_latch_lo <= '0;
            r_page     <= '0;
            r_orient   <= '0;
        end else begin
            if (i_cmd.frame_acc && (r_op == OP_LAT_HI)) begin
                r_latch_hi <= r_data;
            end
            if (i_cmd.frame_acc && (r_op == OP_LAT_LO)) begin
                r_latch_lo <= r_data;
            end
            if (i_cmd.frame_acc && (r_op == OP_PAGE)) begin
                r_page <= r_data[1:0];
            end
            if (i_cfg_wr_en) begin
                r_orient <= i_cfg_wr_data;
            end
        end
    end

    // Display coordinate: swap first, then the flips.
    always_comb begin
        sx    = r_orient[2] ? r_frame_addr[15:8] : r_frame_addr[7:0];
        sy    = r_orient[2] ? r_frame_addr[7:0]  : r_frame_addr[15:8];
        px    = r_orient[0] ? ~sx : sx;
        py    = r_orient[1] ? ~sy : sy;
        inten = r_pal_q[1:0];
    end

    // Output register; a new result may load as the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pix <= is_pixel;
            r_out_data[7:0] <= is_read ? r_frame_q : 8'd0;
            if (is_pixel) begin
                r_out_data[15:8]  <= px;
                r_out_data[23:16] <= py;
                r_out_data[31:24] <= level({r_pal_q[7:6], inten});
                r_out_data[39:32] <= level({r_pal_q[5:4], inten});
                r_out_data[47:40] <= level({r_pal_q[3:2], inten});
            end else begin
                r_out_data[47:8] <= '0;
            end
        end
    end

    assign o_stat.is_pixel = is_pixel;
    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_pix;

endmodule

FILE: sv/video_ram_palette_controller.sv
// ============================================================================
// Video RAM palette controller
// 256x256 frame store with a four-page palette and pixel/color reporting.
// ============================================================================
//
// Channel   Direction  Signals                         Contents
// s_axis    in         tvalid/tready/tdata/tuser       one bus request
// m_axis    out        tvalid/tready/tdata/tuser       one result per request
// cfg       in         i_cfg_wr_en/i_cfg_wr_data       orientation mode
//
// A request steps through capture, frame access and output, with a palette
// read before the output when it reports a pixel, since for a fetch the
// palette read needs the frame byte first. The single-port frame and palette
// stores set these steps. A stalled output adds the stall time before the next
// request is taken. Reset is synchronous; the stores need no clearing pass.
//
module video_ram_palette_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request: [15:0] address, [23:16] data
    input  logic [23:0] i_s_axis_tdata,
    // Request: [3:0] operation
    input  logic [3:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Result: [7:0] read_data, [15:8] pixel_x, [23:16] pixel_y,
    //         [31:24] red, [39:32] green, [47:40] blue
    output logic [47:0] o_m_axis_tdata,
    // Result: [0] pixel_valid
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data
);
    import vrpc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    vrpc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // Stores, registers and output stage.
    vrpc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_s_axis_tuser),
        .i_address       (i_s_axis_tdata[15:0]),
        .i_data          (i_s_axis_tdata[23:16]),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

FILE: sv/vrpc_checker.sv
// ============================================================================
// Video RAM palette controller port checker
// Concurrent checks on the top-level ports, bound to every instance.
// ============================================================================
`include "video_ram_palette_controller_defines.svh"

module vrpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready
);

    // A stalled result keeps its contents.
    `VRPC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // Only one request is in flight: ready drops after each accept.
    `VRPC_ASSERT_NEXT(a_one_in_flight, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request accepted while busy")

    // Results without a pixel carry no coordinate or color.
    `VRPC_ASSERT_NOW(a_no_pixel_zero, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[47:8] == 40'd0, "non-pixel result has pixel fields")

endmodule

bind video_ram_palette_controller vrpc_checker u_vrpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);
